// ===== hdl/tsd_pkg.sv =====
package tsd_pkg;

    // Field widths at the ports
    localparam int ANGLE_W   = 26;
    localparam int SINE_W    = 32;
    localparam int TERMS_W   = 5;
    localparam int THRESH_W  = 16;
    localparam int S_DATA_W  = 32;
    localparam int M_DATA_W  = 40;

    // Angle limit: 360 degrees in Q16, and the in-range angle width
    localparam int          DEG_W         = 25;
    localparam logic [DEG_W-1:0] DEG_LIMIT_Q16 = DEG_W'(360 * 65536);

    // Radians per degree in Q44 (truncated)
    localparam logic [38:0] RAD_PER_DEG_Q44 = 39'd307041569099;

    // Threshold reset, about 1e-6 in Q30
    localparam logic [THRESH_W-1:0] THRESH_RESET = 16'd1074;

    // Internal magnitudes (Q30): x below 2*pi, x^2 below 40, terms below 82,
    // running sum below sinh(2*pi)
    localparam int X_W  = 33;
    localparam int X2_W = 36;
    localparam int T_W  = 37;
    localparam int S_W  = 40;

    // Shared multiplier: A times B, B taken in chunks, MSB chunk first
    localparam int MUL_A_W     = 40;
    localparam int MUL_B_W     = 48;
    localparam int MUL_CHUNK   = 24;
    localparam int MUL_STEPS   = MUL_B_W / MUL_CHUNK;
    localparam int MUL_CNT_W   = (MUL_STEPS > 1) ? $clog2(MUL_STEPS) : 1;
    localparam int MUL_P_W     = MUL_A_W + MUL_B_W;
    localparam int MUL_SHIFT   = 30;
    localparam int MUL_R_W     = 48;

    // Divider: quotient bits resolved per cycle
    localparam int DIV_N_W     = MUL_R_W;
    localparam int DIV_BITS    = 8;
    localparam int DIV_STEPS   = DIV_N_W / DIV_BITS;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

    // Saturation limits of Q2.30
    localparam logic signed [S_W-1:0] SUM_MAX = S_W'(64'sd2147483647);
    localparam logic signed [S_W-1:0] SUM_MIN = -S_W'(64'sd2147483648);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_CONV,
        ST_SQR_GO,
        ST_SQR,
        ST_ACC,
        ST_TMUL,
        ST_DIV,
        ST_DONE
    } tsd_state_t;

    typedef enum logic [1:0] {
        MUL_CONV,
        MUL_SQR,
        MUL_TERM
    } mul_sel_t;

    // Controller to datapath
    typedef struct packed {
        logic     load_in;
        logic     mul_start;
        mul_sel_t mul_sel;
        logic     latch_x;
        logic     latch_x2;
        logic     acc_term;
        logic     div_start;
        logic     latch_t;
        logic     load_out;
    } tsd_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic angle_ok;
        logic mul_done;
        logic div_done;
        logic stop;
        logic out_free;
    } tsd_sts_t;

endpackage

// ===== hdl/tsd_mul.sv =====
// Multi-cycle multiplier: one A x chunk product per cycle, shift-accumulate
module tsd_mul
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [tsd_pkg::MUL_A_W-1:0] a,
    input  logic [tsd_pkg::MUL_B_W-1:0] b,
    output logic                        done,
    output logic                        busy,
    output logic [tsd_pkg::MUL_R_W-1:0] result
);

    logic [tsd_pkg::MUL_A_W-1:0]   a_reg, a_next;
    logic [tsd_pkg::MUL_B_W-1:0]   b_reg, b_next;
    logic [tsd_pkg::MUL_P_W-1:0]   acc_reg, acc_next;
    logic [tsd_pkg::MUL_CNT_W-1:0] step_reg, step_next;
    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [tsd_pkg::MUL_A_W+tsd_pkg::MUL_CHUNK-1:0] prod;

    // one partial product per cycle
    assign prod = a_reg * b_reg[tsd_pkg::MUL_B_W-1 -: tsd_pkg::MUL_CHUNK];

    always_comb
    begin
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            a_next    = a;
            b_next    = b;
            acc_next  = '0;
            step_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            acc_next  = (acc_reg << tsd_pkg::MUL_CHUNK) + tsd_pkg::MUL_P_W'(prod);
            b_next    = b_reg << tsd_pkg::MUL_CHUNK;
            step_next = step_reg + 1'b1;
            if (step_reg == tsd_pkg::MUL_CNT_W'(tsd_pkg::MUL_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

    assign done   = done_reg;
    assign busy   = busy_reg;
    assign result = acc_reg[tsd_pkg::MUL_SHIFT +: tsd_pkg::MUL_R_W];

endmodule

// ===== hdl/tsd_div.sv =====
// Restoring divider, DIV_BITS quotient bits per cycle
module tsd_div
#(
    parameter int D_W = 13
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [tsd_pkg::DIV_N_W-1:0] dividend,
    input  logic [D_W-1:0]              divisor,
    output logic                        done,
    output logic                        busy,
    output logic [tsd_pkg::DIV_N_W-1:0] quotient
);

    logic [tsd_pkg::DIV_N_W-1:0]   num_reg, num_next;
    logic [D_W-1:0]                rem_reg, rem_next;
    logic [D_W-1:0]                d_reg, d_next;
    logic [tsd_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;

    always_comb
    begin
        logic [D_W:0]                trial;
        logic                        ge;
        logic [D_W-1:0]              rem;
        logic [tsd_pkg::DIV_N_W-1:0] num;
        num_next  = num_reg;
        rem_next  = rem_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        rem       = rem_reg;
        num       = num_reg;
        trial     = '0;
        ge        = 1'b0;
        if (start)
        begin
            num_next  = dividend;
            rem_next  = '0;
            d_next    = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // shift-subtract, quotient bits enter at the low end
            for (int i = 0; i < tsd_pkg::DIV_BITS; i++)
            begin
                trial = {rem, num[tsd_pkg::DIV_N_W-1]};
                ge    = (trial >= {1'b0, d_reg});
                rem   = ge ? D_W'(trial - {1'b0, d_reg}) : trial[D_W-1:0];
                num   = {num[tsd_pkg::DIV_N_W-2:0], ge};
            end
            num_next = num;
            rem_next = rem;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == tsd_pkg::DIV_CNT_W'(tsd_pkg::DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        d_reg   <= d_next;
    end

    assign done     = done_reg;
    assign busy     = busy_reg;
    assign quotient = num_reg;

endmodule

// ===== hdl/tsd_datapath.sv =====
// Angle check, radian conversion, term recurrence, sum and output register
module tsd_datapath
#(
    parameter int MAX_TERMS = 16
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  tsd_pkg::tsd_cmd_t              cmd,
    output tsd_pkg::tsd_sts_t              sts,
    input  logic [tsd_pkg::ANGLE_W-1:0]    angle_in,
    input  logic                           cfg_wr_en,
    input  logic [tsd_pkg::THRESH_W-1:0]   cfg_wr_data,
    input  logic                           out_ready,
    output logic                           out_valid,
    output logic [tsd_pkg::SINE_W-1:0]     out_sine,
    output logic                           out_ok,
    output logic [tsd_pkg::TERMS_W-1:0]    out_terms
);

    localparam int K_W   = $clog2(MAX_TERMS);
    localparam int CNT_W = $clog2(MAX_TERMS + 1);
    localparam int D_W   = $clog2((2 * MAX_TERMS) * (2 * MAX_TERMS + 1) + 1);

    logic [tsd_pkg::THRESH_W-1:0] thresh_reg, thresh_next;
    logic [tsd_pkg::DEG_W-1:0]    angle_reg, angle_next;
    logic                         ok_reg, ok_next;
    logic [tsd_pkg::X_W-1:0]      x_reg, x_next;
    logic [tsd_pkg::X2_W-1:0]     x2_reg, x2_next;
    logic [tsd_pkg::T_W-1:0]      t_reg, t_next;
    logic signed [tsd_pkg::S_W-1:0] sum_reg, sum_next;
    logic                         neg_reg, neg_next;
    logic [CNT_W-1:0]             count_reg, count_next;
    logic [K_W-1:0]               k_reg, k_next;
    logic                         oval_reg, oval_next;
    logic [tsd_pkg::SINE_W-1:0]   osine_reg, osine_next;
    logic                         ook_reg, ook_next;
    logic [tsd_pkg::TERMS_W-1:0]  oterms_reg, oterms_next;

    logic [tsd_pkg::MUL_A_W-1:0]  mul_a;
    logic [tsd_pkg::MUL_B_W-1:0]  mul_b;
    logic                         mul_done, mul_busy;
    logic [tsd_pkg::MUL_R_W-1:0]  mul_res;
    logic [D_W-1:0]               div_d;
    logic [D_W-1:0]               kk;
    logic                         div_done, div_busy;
    logic [tsd_pkg::DIV_N_W-1:0]  div_q;
    logic                         in_range;
    logic signed [tsd_pkg::SINE_W-1:0] sine_sat;

    // range check on the raw angle: 0 .. 360 degrees
    assign in_range = !angle_in[tsd_pkg::ANGLE_W-1]
                   && (angle_in[tsd_pkg::ANGLE_W-2:0] <=
                       (tsd_pkg::ANGLE_W-1)'(tsd_pkg::DEG_LIMIT_Q16));

    // multiplier operand select
    always_comb
    begin
        case (cmd.mul_sel)
            tsd_pkg::MUL_CONV:
            begin
                mul_a = tsd_pkg::MUL_A_W'(tsd_pkg::RAD_PER_DEG_Q44);
                mul_b = tsd_pkg::MUL_B_W'(angle_reg);
            end
            tsd_pkg::MUL_SQR:
            begin
                mul_a = tsd_pkg::MUL_A_W'(x_reg);
                mul_b = tsd_pkg::MUL_B_W'(x_reg);
            end
            default:
            begin
                mul_a = tsd_pkg::MUL_A_W'(t_reg);
                mul_b = tsd_pkg::MUL_B_W'(x2_reg);
            end
        endcase
    end

    tsd_mul u_mul
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.mul_start),
        .a      (mul_a),
        .b      (mul_b),
        .done   (mul_done),
        .busy   (mul_busy),
        .result (mul_res)
    );

    // divisor (2k+2)(2k+3)
    assign kk    = D_W'(k_reg);
    assign div_d = (kk + D_W'(1)) * (D_W'(2) * kk + D_W'(3)) * D_W'(2);

    tsd_div #(.D_W(D_W)) u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (mul_res),
        .divisor  (div_d),
        .done     (div_done),
        .busy     (div_busy),
        .quotient (div_q)
    );

    // saturate the sum to Q2.30
    always_comb
    begin
        if (sum_reg > tsd_pkg::SUM_MAX)
            sine_sat = tsd_pkg::SINE_W'(tsd_pkg::SUM_MAX);
        else if (sum_reg < tsd_pkg::SUM_MIN)
            sine_sat = tsd_pkg::SINE_W'(tsd_pkg::SUM_MIN);
        else
            sine_sat = tsd_pkg::SINE_W'(sum_reg);
    end

    // register updates
    always_comb
    begin
        thresh_next = thresh_reg;
        angle_next  = angle_reg;
        ok_next     = ok_reg;
        x_next      = x_reg;
        x2_next     = x2_reg;
        t_next      = t_reg;
        sum_next    = sum_reg;
        neg_next    = neg_reg;
        count_next  = count_reg;
        k_next      = k_reg;
        oval_next   = oval_reg;
        osine_next  = osine_reg;
        ook_next    = ook_reg;
        oterms_next = oterms_reg;

        if (cfg_wr_en)
            thresh_next = cfg_wr_data;

        if (cmd.load_in)
        begin
            angle_next = angle_in[tsd_pkg::DEG_W-1:0];
            ok_next    = in_range;
            sum_next   = '0;
            count_next = '0;
        end

        if (cmd.latch_x)
            x_next = tsd_pkg::X_W'(mul_res);

        if (cmd.latch_x2)
        begin
            x2_next    = tsd_pkg::X2_W'(mul_res);
            t_next     = tsd_pkg::T_W'(x_reg);
            sum_next   = '0;
            neg_next   = 1'b0;
            count_next = '0;
            k_next     = '0;
        end

        // add or subtract the current term
        if (cmd.acc_term)
        begin
            if (neg_reg)
                sum_next = sum_reg - tsd_pkg::S_W'(t_reg);
            else
                sum_next = sum_reg + tsd_pkg::S_W'(t_reg);
            neg_next   = !neg_reg;
            count_next = count_reg + 1'b1;
        end

        if (cmd.latch_t)
        begin
            t_next = tsd_pkg::T_W'(div_q);
            k_next = k_reg + 1'b1;
        end

        // output word
        if (cmd.load_out)
        begin
            oval_next   = 1'b1;
            ook_next    = ok_reg;
            osine_next  = ok_reg ? sine_sat : '0;
            oterms_next = ok_reg ? tsd_pkg::TERMS_W'(count_reg) : '0;
        end
        else if (out_ready)
            oval_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg <= tsd_pkg::THRESH_RESET;
            oval_reg   <= 1'b0;
            count_reg  <= '0;
            k_reg      <= '0;
            neg_reg    <= 1'b0;
            ok_reg     <= 1'b0;
        end
        else
        begin
            thresh_reg <= thresh_next;
            oval_reg   <= oval_next;
            count_reg  <= count_next;
            k_reg      <= k_next;
            neg_reg    <= neg_next;
            ok_reg     <= ok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        angle_reg  <= angle_next;
        x_reg      <= x_next;
        x2_reg     <= x2_next;
        t_reg      <= t_next;
        sum_reg    <= sum_next;
        osine_reg  <= osine_next;
        ook_reg    <= ook_next;
        oterms_reg <= oterms_next;
    end

    // status back to the controller
    assign sts.angle_ok = ok_reg;
    assign sts.mul_done = mul_done;
    assign sts.div_done = div_done;
    assign sts.stop     = (t_reg < tsd_pkg::T_W'(thresh_reg))
                       || (k_reg == K_W'(MAX_TERMS - 1));
    assign sts.out_free = !oval_reg || out_ready;

    assign out_valid = oval_reg;
    assign out_sine  = osine_reg;
    assign out_ok    = ook_reg;
    assign out_terms = oterms_reg;

`ifndef SYNTH
    // the two arithmetic units never run at once
    a_units_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(mul_busy && div_busy))
        else $error("multiplier and divider busy together");

    // the term count stays within the series length
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_TERMS))
        else $error("term count beyond limit");
`endif

endmodule

// ===== hdl/tsd_ctrl.sv =====
// Sequencer: range check, conversion, square, then term loop
module tsd_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output tsd_pkg::tsd_cmd_t cmd,
    input  tsd_pkg::tsd_sts_t sts
);

    tsd_pkg::tsd_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= tsd_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        cmd.mul_sel   = tsd_pkg::MUL_CONV;
        in_ready      = 1'b0;
        unique case (state_reg)
            tsd_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = tsd_pkg::ST_CHECK;
                end
            end
            tsd_pkg::ST_CHECK:
            begin
                if (sts.angle_ok)
                begin
                    cmd.mul_start = 1'b1;
                    cmd.mul_sel   = tsd_pkg::MUL_CONV;
                    state_next    = tsd_pkg::ST_CONV;
                end
                else
                    state_next = tsd_pkg::ST_DONE;
            end
            tsd_pkg::ST_CONV:
            begin
                if (sts.mul_done)
                begin
                    cmd.latch_x = 1'b1;
                    state_next  = tsd_pkg::ST_SQR_GO;
                end
            end
            tsd_pkg::ST_SQR_GO:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = tsd_pkg::MUL_SQR;
                state_next    = tsd_pkg::ST_SQR;
            end
            tsd_pkg::ST_SQR:
            begin
                cmd.mul_sel = tsd_pkg::MUL_SQR;
                if (sts.mul_done)
                begin
                    cmd.latch_x2 = 1'b1;
                    state_next   = tsd_pkg::ST_ACC;
                end
            end
            tsd_pkg::ST_ACC:
            begin
                cmd.acc_term = 1'b1;
                if (sts.stop)
                    state_next = tsd_pkg::ST_DONE;
                else
                begin
                    cmd.mul_start = 1'b1;
                    cmd.mul_sel   = tsd_pkg::MUL_TERM;
                    state_next    = tsd_pkg::ST_TMUL;
                end
            end
            tsd_pkg::ST_TMUL:
            begin
                cmd.mul_sel = tsd_pkg::MUL_TERM;
                if (sts.mul_done)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = tsd_pkg::ST_DIV;
                end
            end
            tsd_pkg::ST_DIV:
            begin
                if (sts.div_done)
                begin
                    cmd.latch_t = 1'b1;
                    state_next  = tsd_pkg::ST_ACC;
                end
            end
            tsd_pkg::ST_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = tsd_pkg::ST_IDLE;
                end
            end
            default:
                state_next = tsd_pkg::ST_IDLE;
        endcase
    end

endmodule

// ===== hdl/taylor_sine_degrees.sv =====
// Channel   Direction  Data bits (low to high)                     Side bits
// s_*       in         angle_deg[25:0], zero pad to 32             -
// m_*       out        sine_value[31:0], terms_used[36:32], pad    tuser: angle_valid
// cfg_*     in         term_threshold[15:0], write when cfg_wr_en  -
//
// One angle at a time. An out-of-range angle goes from the range check straight
// to the output register; a valid one runs conversion and squaring, then up to 16
// terms; each later term costs a multiplier pass, a divider pass and one add.
// The next word is accepted as soon as the previous result sits in the output
// register, even while m_tready is low. Reset sets term_threshold to 1074.
module taylor_sine_degrees
#(
    parameter int MAX_TERMS = 16
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [tsd_pkg::S_DATA_W-1:0]    s_tdata,   // angle_deg[25:0]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [tsd_pkg::M_DATA_W-1:0]    m_tdata,   // sine_value[31:0], terms_used[36:32]
    output logic                            m_tuser,   // angle_valid
    input  logic                            cfg_wr_en,
    input  logic [tsd_pkg::THRESH_W-1:0]    cfg_wr_data
);

    tsd_pkg::tsd_cmd_t            cmd;
    tsd_pkg::tsd_sts_t            sts;
    logic [tsd_pkg::SINE_W-1:0]   out_sine;
    logic [tsd_pkg::TERMS_W-1:0]  out_terms;

    tsd_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    tsd_datapath #(.MAX_TERMS(MAX_TERMS)) u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .angle_in    (s_tdata[tsd_pkg::ANGLE_W-1:0]),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .out_ready   (m_tready),
        .out_valid   (m_tvalid),
        .out_sine    (out_sine),
        .out_ok      (m_tuser),
        .out_terms   (out_terms)
    );

    // pack result word
    assign m_tdata = {{(tsd_pkg::M_DATA_W - tsd_pkg::SINE_W - tsd_pkg::TERMS_W){1'b0}},
                      out_terms, out_sine};

`ifndef SYNTH
    // one angle in flight: ready drops right after a word is taken
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while busy");

    // an out-of-range angle gives an all-zero word
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata == '0))
        else $error("nonzero result for out-of-range angle");

    // a valid angle always uses at least one term
    a_valid_terms: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata[36:32] != 5'd0))
        else $error("valid result with no terms");
`endif

endmodule
